@@ hdl/crtc_pkg.sv @@
package crtc_pkg;

    localparam int REG_COUNT   = 18;
    localparam int VSYNC_WIDTH = 16;
    localparam int ADDR_BITS   = 14;
    localparam int VS_BITS     = (VSYNC_WIDTH > 1) ? $clog2(VSYNC_WIDTH) : 1;

    typedef logic [1:0]           t_cmd;
    typedef logic [4:0]           t_reg_idx;
    typedef logic [7:0]           t_byte;
    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [4:0]           t_raster;

    localparam t_cmd CMD_TICK  = 2'd0;
    localparam t_cmd CMD_WRITE = 2'd1;
    localparam t_cmd CMD_READ  = 2'd2;
    localparam t_cmd CMD_LATCH = 2'd3;

    localparam t_reg_idx REG_HTOTAL     = 5'd0;
    localparam t_reg_idx REG_HDISP      = 5'd1;
    localparam t_reg_idx REG_HSYNC_POS  = 5'd2;
    localparam t_reg_idx REG_SYNC_WIDTH = 5'd3;
    localparam t_reg_idx REG_VTOTAL     = 5'd4;
    localparam t_reg_idx REG_VADJ       = 5'd5;
    localparam t_reg_idx REG_VDISP      = 5'd6;
    localparam t_reg_idx REG_VSYNC_POS  = 5'd7;
    localparam t_reg_idx REG_MODE       = 5'd8;
    localparam t_reg_idx REG_MAX_RASTER = 5'd9;
    localparam t_reg_idx REG_CUR_START  = 5'd10;
    localparam t_reg_idx REG_CUR_END    = 5'd11;
    localparam t_reg_idx REG_START_HI   = 5'd12;
    localparam t_reg_idx REG_START_LO   = 5'd13;
    localparam t_reg_idx REG_CUR_HI     = 5'd14;
    localparam t_reg_idx REG_CUR_LO     = 5'd15;
    localparam t_reg_idx REG_PEN_HI     = 5'd16;
    localparam t_reg_idx REG_PEN_LO     = 5'd17;

    localparam logic [1:0] BLINK_OFF  = 2'd1;
    localparam logic [1:0] BLINK_FAST = 2'd2;
    localparam logic [1:0] BLINK_SLOW = 2'd3;

    typedef struct packed {
        t_byte        read_data;
        t_addr        ma;
        t_raster      ra;
        logic [7:0]   hcc;
        logic [6:0]   vcc;
        logic         de;
        logic         hsync;
        logic         vsync;
        logic         cursor;
        logic         hborder;
        logic         vborder;
    } t_result;

    // Writable bits of each register.
    function automatic t_byte reg_mask(t_reg_idx idx);
        t_byte m;
        case (idx)
            REG_VTOTAL, REG_VDISP, REG_VSYNC_POS, REG_CUR_START: m = 8'h7f;
            REG_VADJ, REG_MAX_RASTER, REG_CUR_END:              m = 8'h1f;
            REG_MODE:                                           m = 8'h03;
            REG_START_HI, REG_CUR_HI, REG_PEN_HI:               m = 8'h3f;
            default:                                            m = 8'hff;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/crtc_if.sv @@
interface crtc_in_if;
    import crtc_pkg::*;
    logic     valid;
    logic     ready;
    t_cmd     cmd;
    t_reg_idx reg_index;
    t_byte    write_data;

    modport source (output valid, output cmd, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input cmd, input reg_index, input write_data,
                    output ready);
endinterface

interface crtc_out_if;
    import crtc_pkg::*;
    logic       valid;
    logic       ready;
    t_byte      read_data;
    t_addr      ma;
    t_raster    ra;
    logic [7:0] hcc;
    logic [6:0] vcc;
    logic       de;
    logic       hsync;
    logic       vsync;
    logic       cursor;
    logic       hborder;
    logic       vborder;

    modport source (output valid, output read_data, output ma, output ra, output hcc,
                    output vcc, output de, output hsync, output vsync, output cursor,
                    output hborder, output vborder, input ready);
    modport sink   (input valid, input read_data, input ma, input ra, input hcc,
                    input vcc, input de, input hsync, input vsync, input cursor,
                    input hborder, input vborder, output ready);
endinterface

@@ hdl/crt_controller_timing_core.sv @@
// CRT timing controller core.
// The input channel i_in carries one command per transfer: a character-clock
// tick, a masked register write, a register read or a light-pen latch.
// Every accepted command yields exactly one result on o_out, holding the
// refresh address, raster line, both character counters, the sync pulses,
// display enable, the border flags, the cursor and, for a read, the data.
// The result is loaded into the output register at the edge of the input
// transfer and is offered on o_out from there. Throughput is one command per
// cycle while the receiver takes results, set by the single pass of
// next-state logic between the state registers and the result register.
// i_in.ready is high whenever the output register is empty or is being
// emptied in the same cycle. While the receiver stalls, the result holds and
// i_in.ready stays low, so the next command waits with the sender.
// Reset (synchronous, active low) clears the register file, all counters,
// addresses and sync state, sets the cursor blink phase to visible and
// empties the output register.
module crt_controller_timing_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crtc_in_if.sink     i_in,
    crtc_out_if.source  o_out
);
    import crtc_pkg::*;

    t_byte       r_regs [REG_COUNT];
    t_byte       n_regs [REG_COUNT];
    logic [7:0]  r_hcc, n_hcc;
    logic [6:0]  r_row, n_row;
    logic [4:0]  r_line, n_line;
    logic        r_adj, n_adj;
    logic [5:0]  r_adj_cnt, n_adj_cnt;
    t_addr       r_ma, n_ma;
    t_addr       r_row_base, n_row_base;
    logic        r_hs, n_hs;
    logic [4:0]  r_hs_rem, n_hs_rem;
    logic        r_vs, n_vs;
    logic [VS_BITS-1:0] r_vs_lines, n_vs_lines;
    logic [3:0]  r_frame, n_frame;
    logic        r_odd, n_odd;
    logic        r_blink, n_blink;
    logic        r_valid;
    t_result     r_res, n_res;

    logic        accept;
    logic        end_of_line;
    logic        at_max_raster;
    logic        do_frame;
    logic        do_vcheck;
    t_addr       next_addr;
    t_addr       start_addr;
    t_addr       cur_addr;
    t_raster     ra_now;
    t_raster     ra_out;
    t_raster     cur_s;
    t_raster     cur_e;
    logic [1:0]  blink_mode;
    logic [3:0]  hs_width;
    logic        hen;
    logic        ven;
    logic        vis;

    function automatic t_raster ra_of(t_byte mode, logic [4:0] line, logic odd);
        return (mode[1:0] == 2'b11) ? {line[3:0], odd} : line;
    endfunction

    assign accept       = i_in.valid && i_in.ready;
    assign i_in.ready   = !r_valid || o_out.ready;

    always_comb begin
        n_regs     = r_regs;
        n_hcc      = r_hcc;
        n_row      = r_row;
        n_line     = r_line;
        n_adj      = r_adj;
        n_adj_cnt  = r_adj_cnt;
        n_ma       = r_ma;
        n_row_base = r_row_base;
        n_hs       = r_hs;
        n_hs_rem   = r_hs_rem;
        n_vs       = r_vs;
        n_vs_lines = r_vs_lines;
        n_frame    = r_frame;
        n_odd      = r_odd;
        n_blink    = r_blink;
        n_res      = r_res;
        n_res.read_data = '0;

        ra_now        = ra_of(r_regs[REG_MODE], r_line, r_odd);
        end_of_line   = (r_hcc == r_regs[REG_HTOTAL]);
        at_max_raster = ({3'b000, ra_now} == r_regs[REG_MAX_RASTER]);
        next_addr     = r_ma + t_addr'(1);
        start_addr    = t_addr'({r_regs[REG_START_HI], r_regs[REG_START_LO]});
        blink_mode    = r_regs[REG_CUR_START][6:5];
        hs_width      = r_regs[REG_SYNC_WIDTH][3:0];
        do_frame      = 1'b0;
        do_vcheck     = 1'b0;

        case (i_in.cmd)
            CMD_TICK: begin
                if (r_hs) begin
                    if (r_hs_rem > 5'd1) begin
                        n_hs_rem = r_hs_rem - 5'd1;
                    end else begin
                        n_hs_rem = '0;
                        n_hs     = 1'b0;
                    end
                end
                // Row base is captured just past the displayed part of the
                // last raster line of a row.
                if (at_max_raster && ({1'b0, r_hcc} + 9'd1 == {1'b0, r_regs[REG_HDISP]})) begin
                    n_row_base = next_addr;
                end
                n_hcc = end_of_line ? 8'd0 : r_hcc + 8'd1;
                n_ma  = next_addr;
                if (end_of_line) begin
                    n_ma = n_row_base;
                    if (r_vs) begin
                        if (r_vs_lines == VS_BITS'(VSYNC_WIDTH - 1)) begin
                            n_vs_lines = '0;
                            n_vs       = 1'b0;
                        end else begin
                            n_vs_lines = r_vs_lines + VS_BITS'(1);
                        end
                    end
                    if (r_adj) begin
                        n_adj_cnt = r_adj_cnt + 6'd1;
                        n_line    = r_line + 5'd1;
                        if ({2'b00, n_adj_cnt} >= r_regs[REG_VADJ]) begin
                            do_frame = 1'b1;
                        end
                    end else if (!at_max_raster) begin
                        n_line = r_line + 5'd1;
                    end else begin
                        n_line = '0;
                        if ({1'b0, r_row} == r_regs[REG_VTOTAL]) begin
                            if (r_regs[REG_VADJ] != 8'd0) begin
                                n_adj     = 1'b1;
                                n_adj_cnt = '0;
                            end else begin
                                do_frame = 1'b1;
                            end
                        end else begin
                            n_row     = r_row + 7'd1;
                            do_vcheck = 1'b1;
                        end
                    end
                    if (do_frame) begin
                        n_frame = r_frame + 4'd1;
                        if (r_regs[REG_MODE][0]) begin
                            n_odd = !r_odd;
                        end
                        n_adj      = 1'b0;
                        n_adj_cnt  = '0;
                        n_row      = '0;
                        n_line     = '0;
                        n_ma       = start_addr;
                        n_row_base = start_addr;
                        n_vs       = 1'b0;
                        n_vs_lines = '0;
                        case (blink_mode)
                            BLINK_FAST: begin
                                if (n_frame[2:0] == 3'd0) n_blink = !r_blink;
                            end
                            BLINK_SLOW: begin
                                if (n_frame == 4'd0) n_blink = !r_blink;
                            end
                            default: n_blink = 1'b1;
                        endcase
                        do_vcheck = 1'b1;
                    end
                    if (do_vcheck && !n_vs && !n_adj && n_line == 5'd0 &&
                        {1'b0, n_row} == r_regs[REG_VSYNC_POS]) begin
                        n_vs       = 1'b1;
                        n_vs_lines = '0;
                    end
                end
                if (!n_hs && n_hcc == r_regs[REG_HSYNC_POS]) begin
                    n_hs     = 1'b1;
                    n_hs_rem = (hs_width != 4'd0) ? {1'b0, hs_width} : 5'd16;
                end
            end
            CMD_WRITE: begin
                if (i_in.reg_index < t_reg_idx'(REG_COUNT) &&
                    i_in.reg_index != REG_PEN_HI && i_in.reg_index != REG_PEN_LO) begin
                    n_regs[i_in.reg_index] = i_in.write_data & reg_mask(i_in.reg_index);
                end
            end
            CMD_READ: begin
                if (i_in.reg_index >= REG_CUR_HI && i_in.reg_index <= REG_PEN_LO) begin
                    n_res.read_data = r_regs[i_in.reg_index];
                end else begin
                    n_res.read_data = 8'hff;
                end
            end
            default: begin
                n_regs[REG_PEN_HI] = {2'b00, r_ma[13:8]};
                n_regs[REG_PEN_LO] = r_ma[7:0];
            end
        endcase

        // Outputs reflect the state after this command.
        ra_out   = ra_of(n_regs[REG_MODE], n_line, n_odd);
        hen      = (n_hcc < n_regs[REG_HDISP]);
        ven      = !n_adj && ({1'b0, n_row} < n_regs[REG_VDISP]);
        cur_s    = n_regs[REG_CUR_START][4:0];
        cur_e    = n_regs[REG_CUR_END][4:0];
        cur_addr = t_addr'({n_regs[REG_CUR_HI], n_regs[REG_CUR_LO]});
        vis      = (cur_s <= cur_e) ? (ra_out >= cur_s && ra_out <= cur_e)
                                    : (ra_out >= cur_s || ra_out <= cur_e);

        n_res.ma      = n_ma;
        n_res.ra      = ra_out;
        n_res.hcc     = n_hcc;
        n_res.vcc     = n_row;
        n_res.de      = hen && ven;
        n_res.hsync   = n_hs;
        n_res.vsync   = n_vs;
        n_res.hborder = !hen;
        n_res.vborder = !ven;
        case (n_regs[REG_CUR_START][6:5])
            BLINK_OFF:              n_res.cursor = 1'b0;
            BLINK_FAST, BLINK_SLOW: n_res.cursor = vis && (n_ma == cur_addr) && n_blink;
            default:                n_res.cursor = vis && (n_ma == cur_addr);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
            r_hcc      <= '0;
            r_row      <= '0;
            r_line     <= '0;
            r_adj      <= 1'b0;
            r_adj_cnt  <= '0;
            r_ma       <= '0;
            r_row_base <= '0;
            r_hs       <= 1'b0;
            r_hs_rem   <= '0;
            r_vs       <= 1'b0;
            r_vs_lines <= '0;
            r_frame    <= '0;
            r_odd      <= 1'b0;
            r_blink    <= 1'b1;
            r_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_regs     <= n_regs;
                r_hcc      <= n_hcc;
                r_row      <= n_row;
                r_line     <= n_line;
                r_adj      <= n_adj;
                r_adj_cnt  <= n_adj_cnt;
                r_ma       <= n_ma;
                r_row_base <= n_row_base;
                r_hs       <= n_hs;
                r_hs_rem   <= n_hs_rem;
                r_vs       <= n_vs;
                r_vs_lines <= n_vs_lines;
                r_frame    <= n_frame;
                r_odd      <= n_odd;
                r_blink    <= n_blink;
                r_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.read_data = r_res.read_data;
    assign o_out.ma        = r_res.ma;
    assign o_out.ra        = r_res.ra;
    assign o_out.hcc       = r_res.hcc;
    assign o_out.vcc       = r_res.vcc;
    assign o_out.de        = r_res.de;
    assign o_out.hsync     = r_res.hsync;
    assign o_out.vsync     = r_res.vsync;
    assign o_out.cursor    = r_res.cursor;
    assign o_out.hborder   = r_res.hborder;
    assign o_out.vborder   = r_res.vborder;

endmodule

@@ hdl/crtc_checker.sv @@
module crtc_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  crtc_pkg::t_cmd    i_cmd,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  crtc_pkg::t_byte   i_read_data,
    input  crtc_pkg::t_addr   i_ma,
    input  logic [7:0]        i_hcc
);
    import crtc_pkg::*;

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    // Every accepted command produces a result on the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted command gave no result");

    // Only a register read returns nonzero read data.
    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_cmd != CMD_READ) |=> (i_read_data == 8'd0))
        else $error("read data on a non-read command");

    // With the output register empty, the block must take input.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_ma) && $stable(i_hcc)))
        else $error("stalled result changed");

endmodule

bind crt_controller_timing_core crtc_checker u_crtc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_cmd       (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_read_data (o_out.read_data),
    .i_ma        (o_out.ma),
    .i_hcc       (o_out.hcc)
);
